### sv/cartridge_bank_mapper_irq_unit_macros.svh
// assertion macros for the cartridge bank mapper irq unit
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_UNIT_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define CBM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CBM_ASSERT_NOW(lbl, ante, cons, msg)
`define CBM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### sv/cbm_pkg.sv
`default_nettype none

package cbm_pkg;

    localparam int PRG_W        = 8;
    localparam int CHR_BANK_W   = 12;
    localparam int CHR_LOW_W    = 8;
    localparam int CHR_TOP_W    = 4;
    localparam int SLOTS        = 8;
    localparam int SLOT_W       = 3;
    localparam int OFFSET_W     = 10;
    localparam int CPU_ADDR_W   = 16;
    localparam int CPU_DATA_W   = 8;
    localparam int PPU_ADDR_W   = 13;
    localparam int CHR_ADDR_W   = 22;
    localparam int CHR_RAM_BYTES = 2048;
    localparam int CHR_RAM_AW   = $clog2(CHR_RAM_BYTES);
    localparam int PRESCALE_W   = 9;
    localparam int IRQ_CNT_W    = 8;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [PRESCALE_W-1:0] PRESCALE_WRAP = 9'd338;
    localparam logic [PRESCALE_W-1:0] PRESCALE_STEP = 9'd3;
    localparam logic [IRQ_CNT_W-1:0]  IRQ_CNT_TOP   = 8'hFF;

    localparam logic [CHR_LOW_W-1:0] VRAM_ENABLE_CODE  = 8'hC8;
    localparam logic [CHR_LOW_W-1:0] VRAM_DISABLE_CODE = 8'h88;
    localparam logic [CHR_LOW_W-1:0] CHR_RAM_BANK_A    = 8'd4;
    localparam logic [CHR_LOW_W-1:0] CHR_RAM_BANK_B    = 8'd5;

    localparam logic [CPU_ADDR_W-1:0] ADDR_PRG_LOW    = 16'h8010;
    localparam logic [CPU_ADDR_W-1:0] ADDR_PRG_HIGH   = 16'hA010;
    localparam logic [CPU_ADDR_W-1:0] ADDR_MIRROR     = 16'h9400;
    localparam logic [CPU_ADDR_W-1:0] ADDR_RELOAD_LO  = 16'hF000;
    localparam logic [CPU_ADDR_W-1:0] ADDR_RELOAD_HI  = 16'hF004;
    localparam logic [CPU_ADDR_W-1:0] ADDR_IRQ_CTRL   = 16'hF008;
    localparam logic [CPU_ADDR_W-1:0] ADDR_CHR_FIRST  = 16'hB000;
    localparam logic [CPU_ADDR_W-1:0] ADDR_CHR_LAST   = 16'hE00C;

    localparam logic [PRG_W-1:0]      PRG_MAX_RESET = 8'd255;
    localparam logic [CHR_BANK_W-1:0] CHR_MAX_RESET = 12'd4095;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PRG_MAX = 2'd0,
        CFG_CHR_MAX = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic                  cpu_write;
        logic [CPU_ADDR_W-1:0] cpu_address;
        logic [CPU_DATA_W-1:0] cpu_data;
        logic [PPU_ADDR_W-1:0] ppu_address;
        logic                  ppu_write;
    } in_word_t;

    typedef struct packed {
        logic [PRG_W-1:0]      prg_bank_low;
        logic [PRG_W-1:0]      prg_bank_high;
        logic [1:0]            mirroring;
        logic                  irq_line;
        logic                  chr_from_ram;
        logic [CHR_ADDR_W-1:0] chr_address;
        logic                  chr_write_enable;
    } out_word_t;

    typedef struct packed {
        logic                  apply;
        logic [CPU_ADDR_W-1:0] addr;
        logic [CPU_DATA_W-1:0] data;
    } cpu_wr_t;

    typedef struct packed {
        logic [SLOTS-1:0][CHR_LOW_W-1:0] low;
        logic [SLOTS-1:0][CHR_TOP_W-1:0] top;
        logic                            vram_disabled;
    } chr_view_t;

    function automatic logic [CHR_BANK_W-1:0] limit_bank(
        input logic [CHR_BANK_W-1:0] bank,
        input logic [CHR_BANK_W-1:0] max_bank
    );
        return (bank > max_bank) ? (bank & max_bank) : bank;
    endfunction

endpackage

`default_nettype wire

### sv/cbm_cpu_regs.sv
`default_nettype none

module cbm_cpu_regs
    import cbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cpu_wr_t               wr,
    input  logic [PRG_W-1:0]      prg_max,
    output logic [PRG_W-1:0]      prg_low_next,
    output logic [PRG_W-1:0]      prg_high_next,
    output logic [1:0]            mirror_next,
    output chr_view_t             view_next,
    output logic [IRQ_CNT_W-1:0]  irq_reload
);

    logic [PRG_W-1:0]     prg_low_reg;
    logic [PRG_W-1:0]     prg_high_reg;
    logic [1:0]           mirror_reg;
    chr_view_t            view_reg;
    logic [IRQ_CNT_W-1:0] reload_reg;
    logic [IRQ_CNT_W-1:0] reload_next;
    logic [SLOT_W-1:0]    chr_slot;
    logic [PRG_W-1:0]     prg_limited;

    assign chr_slot = (wr.addr[13:11] | {2'b00, wr.addr[3]}) + 3'd2;
    assign prg_limited = PRG_W'(limit_bank({4'b0000, wr.data}, {4'b0000, prg_max}));

    always_comb
    begin
        prg_low_next  = prg_low_reg;
        prg_high_next = prg_high_reg;
        mirror_next   = mirror_reg;
        view_next     = view_reg;
        reload_next   = reload_reg;
        if (wr.apply)
        begin
            if (wr.addr == ADDR_PRG_LOW)
            begin
                prg_low_next = prg_limited;
            end
            else if (wr.addr == ADDR_PRG_HIGH)
            begin
                prg_high_next = prg_limited;
            end
            else if (wr.addr == ADDR_MIRROR)
            begin
                mirror_next = wr.data[1:0];
            end
            else if (wr.addr == ADDR_RELOAD_LO)
            begin
                reload_next = {reload_reg[7:4], wr.data[3:0]};
            end
            else if (wr.addr == ADDR_RELOAD_HI)
            begin
                reload_next = {wr.data[3:0], reload_reg[3:0]};
            end
            else if (wr.addr >= ADDR_CHR_FIRST && wr.addr <= ADDR_CHR_LAST)
            begin
                if (wr.addr[2])
                begin
                    view_next.low[chr_slot] = {wr.data[3:0], view_reg.low[chr_slot][3:0]};
                    view_next.top[chr_slot] = wr.data[7:4];
                end
                else
                begin
                    view_next.low[chr_slot] = {view_reg.low[chr_slot][7:4], wr.data[3:0]};
                end
                if (chr_slot == '0)
                begin
                    if (view_next.low[0] == VRAM_ENABLE_CODE)
                    begin
                        view_next.vram_disabled = 1'b0;
                    end
                    else if (view_next.low[0] == VRAM_DISABLE_CODE)
                    begin
                        view_next.vram_disabled = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_low_reg  <= '0;
            prg_high_reg <= '0;
            mirror_reg   <= '0;
            reload_reg   <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                view_reg.low[i] <= CHR_LOW_W'(i);
                view_reg.top[i] <= '0;
            end
            view_reg.vram_disabled <= 1'b0;
        end
        else
        begin
            prg_low_reg  <= prg_low_next;
            prg_high_reg <= prg_high_next;
            mirror_reg   <= mirror_next;
            reload_reg   <= reload_next;
            view_reg     <= view_next;
        end
    end

    assign irq_reload = reload_next;

endmodule

`default_nettype wire

### sv/cbm_irq.sv
`default_nettype none

module cbm_irq
    import cbm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick,
    input  cpu_wr_t              wr,
    input  logic [IRQ_CNT_W-1:0] reload,
    output logic                 pending_next
);

    `include "cartridge_bank_mapper_irq_unit_macros.svh"

    logic                  enabled_reg;
    logic                  enabled_next;
    logic [PRESCALE_W-1:0] prescale_reg;
    logic [PRESCALE_W-1:0] prescale_next;
    logic [IRQ_CNT_W-1:0]  counter_reg;
    logic [IRQ_CNT_W-1:0]  counter_next;
    logic                  pending_reg;

    always_comb
    begin
        enabled_next  = enabled_reg;
        prescale_next = prescale_reg;
        counter_next  = counter_reg;
        pending_next  = pending_reg;
        if (wr.apply && wr.addr == ADDR_IRQ_CTRL)
        begin
            enabled_next = wr.data[1];
            if (wr.data[1])
            begin
                prescale_next = '0;
                counter_next  = reload;
            end
            pending_next = 1'b0;
        end
        // one tick per cpu cycle, after the register write
        if (tick && enabled_next)
        begin
            if (prescale_next < PRESCALE_WRAP)
            begin
                prescale_next = prescale_next + PRESCALE_STEP;
            end
            else
            begin
                prescale_next = prescale_next - PRESCALE_WRAP;
                if (counter_next != IRQ_CNT_TOP)
                begin
                    counter_next = counter_next + 1'b1;
                end
                else
                begin
                    counter_next = reload;
                    pending_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg  <= 1'b0;
            prescale_reg <= '0;
            counter_reg  <= '0;
            pending_reg  <= 1'b0;
        end
        else
        begin
            enabled_reg  <= enabled_next;
            prescale_reg <= prescale_next;
            counter_reg  <= counter_next;
            pending_reg  <= pending_next;
        end
    end

    `CBM_ASSERT_NEXT(a_pending_holds_idle, !tick, $stable(pending_reg), "irq changed with no cycle")
    `CBM_ASSERT_NOW(a_prescale_range, 1'b1, prescale_reg <= PRESCALE_WRAP + PRESCALE_STEP - 1'b1, "prescaler out of range")
    `CBM_ASSERT_NEXT(a_disabled_frozen, !enabled_reg && !(wr.apply && wr.addr == ADDR_IRQ_CTRL), $stable(prescale_reg) && $stable(counter_reg), "disabled irq counter moved")

endmodule

`default_nettype wire

### sv/cbm_chr_xlate.sv
`default_nettype none

module cbm_chr_xlate
    import cbm_pkg::*;
(
    input  logic [PPU_ADDR_W-1:0] ppu_address,
    input  logic                  ppu_write,
    input  chr_view_t             view,
    input  logic [CHR_BANK_W-1:0] chr_max,
    output logic                  from_ram,
    output logic [CHR_ADDR_W-1:0] address,
    output logic                  write_enable
);

    logic [SLOT_W-1:0]     slot;
    logic [OFFSET_W-1:0]   offset;
    logic [CHR_LOW_W-1:0]  low;
    logic [CHR_BANK_W-1:0] bank;

    assign slot   = ppu_address[PPU_ADDR_W-1 -: SLOT_W];
    assign offset = ppu_address[OFFSET_W-1:0];
    assign low    = view.low[slot];
    assign bank   = limit_bank({view.top[slot], low}, chr_max);

    assign from_ram = (low == CHR_RAM_BANK_A || low == CHR_RAM_BANK_B) && !view.vram_disabled;
    assign address  = from_ram
        ? CHR_ADDR_W'({low[0], offset})
        : {bank, offset};
    assign write_enable = from_ram && ppu_write;

endmodule

`default_nettype wire

### sv/cartridge_bank_mapper_irq_unit.sv
// channel  | handshake               | word
// ---------+-------------------------+---------------------------------------
// input    | in_valid / in_ready     | in_word: cpu write plus ppu address
// output   | out_valid / out_ready   | out_word: banks, mirroring, irq, chr
// config   | cfg_we                  | cfg_index, cfg_data
//
// one word per clock sustained while out_ready stays high
// stage one holds the accepted word, the register write, irq tick and chr translation
// run between it and the output register
// reset clears both stages, the bank registers (chr low byte of slot i is i), irq state,
// and sets the bank limits to their maximum
// a stalled output keeps its word; stage one keeps one more, then in_ready drops
`default_nettype none

module cartridge_bank_mapper_irq_unit
    import cbm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_word_t               in_word,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_word_t              out_word,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    `include "cartridge_bank_mapper_irq_unit_macros.svh"

    logic                  s1_valid_reg;
    in_word_t              s1_word_reg;
    logic                  out_valid_reg;
    out_word_t             out_word_reg;
    out_word_t             result;
    logic [PRG_W-1:0]      prg_max_reg;
    logic [CHR_BANK_W-1:0] chr_max_reg;
    logic                  advance;
    logic                  in_take;
    cpu_wr_t               wr;
    chr_view_t             view_next;
    logic [IRQ_CNT_W-1:0]  irq_reload;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    assign wr.apply = advance && s1_word_reg.cpu_write;
    assign wr.addr  = s1_word_reg.cpu_address;
    assign wr.data  = s1_word_reg.cpu_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_max_reg <= PRG_MAX_RESET;
            chr_max_reg <= CHR_MAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PRG_MAX: prg_max_reg <= cfg_data[PRG_W-1:0];
                CFG_CHR_MAX: chr_max_reg <= cfg_data[CHR_BANK_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_take || (s1_valid_reg && !advance);
            out_valid_reg <= advance || (out_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_word_reg <= in_word;
        end
        if (advance)
        begin
            out_word_reg <= result;
        end
    end

    cbm_cpu_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr            (wr),
        .prg_max       (prg_max_reg),
        .prg_low_next  (result.prg_bank_low),
        .prg_high_next (result.prg_bank_high),
        .mirror_next   (result.mirroring),
        .view_next     (view_next),
        .irq_reload    (irq_reload)
    );

    cbm_irq u_irq (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (advance),
        .wr           (wr),
        .reload       (irq_reload),
        .pending_next (result.irq_line)
    );

    cbm_chr_xlate u_chr (
        .ppu_address  (s1_word_reg.ppu_address),
        .ppu_write    (s1_word_reg.ppu_write),
        .view         (view_next),
        .chr_max      (chr_max_reg),
        .from_ram     (result.chr_from_ram),
        .address      (result.chr_address),
        .write_enable (result.chr_write_enable)
    );

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    `CBM_ASSERT_NOW(a_ram_addr_range, out_valid_reg && out_word_reg.chr_from_ram, out_word_reg.chr_address[CHR_ADDR_W-1:CHR_RAM_AW] == '0, "chr ram address out of range")
    `CBM_ASSERT_NOW(a_we_needs_ram, out_valid_reg && out_word_reg.chr_write_enable, out_word_reg.chr_from_ram, "chr write enable without ram")
    `CBM_ASSERT_NEXT(a_stage_one_kept, s1_valid_reg && out_valid_reg && !out_ready, s1_valid_reg && $stable(s1_word_reg), "stage one word lost under stall")

endmodule

`default_nettype wire

### verif/tb_cartridge_bank_mapper_irq_unit.sv
module tb_cartridge_bank_mapper_irq_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cbm_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SEGMENTS      = 6;
    localparam int SEGMENT_WORDS = 260;
    localparam int MAX_REPORTS   = 40;

    // indexes past the two limit registers, ignored by the block
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    in_word_t               in_word   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_word_t              out_word;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    cartridge_bank_mapper_irq_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // mapper state as the predictor sees it
    logic [CHR_LOW_W-1:0]  chr_low_q [SLOTS];
    logic [CHR_TOP_W-1:0]  chr_top_q [SLOTS];
    bit                    vram_off_q;
    logic [PRG_W-1:0]      prg_bank_q [2];
    logic [1:0]            mirror_q;
    bit                    irq_on_q;
    int unsigned           prescale_q;
    logic [IRQ_CNT_W-1:0]  irq_count_q;
    logic [IRQ_CNT_W-1:0]  irq_reload_q;
    bit                    irq_pend_q;
    logic [PRG_W-1:0]      prg_limit_q;
    logic [CHR_BANK_W-1:0] chr_limit_q;

    typedef struct {
        in_word_t  word;
        bit        typed;
        out_word_t result;
    } vector_t;

    vector_t   vectors [$];
    out_word_t mapped_due [$];
    out_word_t due;

    int src_idle_pct;
    int snk_idle_pct;
    int errors;
    int stall_cycles;
    int n_words;
    int n_irq_words;
    int n_ram_words;
    int n_ram_writes;
    int n_settings;

    function automatic logic [CHR_BANK_W-1:0] clip_bank(
        input logic [CHR_BANK_W-1:0] bank,
        input logic [CHR_BANK_W-1:0] lim
    );
        return (bank > lim) ? (bank & lim) : bank;
    endfunction

    task automatic reset_mapper();
        for (int i = 0; i < SLOTS; i++)
        begin
            chr_low_q[i] = CHR_LOW_W'(i);
            chr_top_q[i] = '0;
        end
        vram_off_q    = 1'b0;
        prg_bank_q[0] = '0;
        prg_bank_q[1] = '0;
        mirror_q      = '0;
        irq_on_q      = 1'b0;
        prescale_q    = 0;
        irq_count_q   = '0;
        irq_reload_q  = '0;
        irq_pend_q    = 1'b0;
        prg_limit_q   = PRG_MAX_RESET;
        chr_limit_q   = CHR_MAX_RESET;
    endtask

    // one cpu cycle: register write, irq tick, chr translation
    function automatic out_word_t step_mapper(input in_word_t w);
        int unsigned           a;
        int unsigned           slot;
        logic [CPU_DATA_W-1:0] d;
        logic [CHR_LOW_W-1:0]  low;
        logic [CHR_BANK_W-1:0] bank;
        logic [SLOT_W-1:0]     ps;
        bit                    ram;
        out_word_t             r;

        a = w.cpu_address;
        d = w.cpu_data;
        if (w.cpu_write)
        begin
            if (w.cpu_address == ADDR_PRG_LOW)
            begin
                bank = clip_bank({4'h0, d}, {4'h0, prg_limit_q});
                prg_bank_q[0] = bank[PRG_W-1:0];
            end
            else if (w.cpu_address == ADDR_PRG_HIGH)
            begin
                bank = clip_bank({4'h0, d}, {4'h0, prg_limit_q});
                prg_bank_q[1] = bank[PRG_W-1:0];
            end
            else if (w.cpu_address == ADDR_MIRROR)
                mirror_q = d[1:0];
            else if (w.cpu_address == ADDR_RELOAD_LO)
                irq_reload_q[3:0] = d[3:0];
            else if (w.cpu_address == ADDR_RELOAD_HI)
                irq_reload_q[7:4] = d[3:0];
            else if (w.cpu_address == ADDR_IRQ_CTRL)
            begin
                irq_on_q = d[1];
                if (irq_on_q)
                begin
                    prescale_q  = 0;
                    irq_count_q = irq_reload_q;
                end
                irq_pend_q = 1'b0;
            end
            else if (w.cpu_address >= ADDR_CHR_FIRST && w.cpu_address <= ADDR_CHR_LAST)
            begin
                slot = (((((a & 32'd8) | (a >> 8)) >> 3) + 2) % SLOTS);
                if (a[2])
                begin
                    chr_low_q[slot][7:4] = d[3:0];
                    chr_top_q[slot]      = d[7:4];
                end
                else
                    chr_low_q[slot][3:0] = d[3:0];
                if (slot == 0)
                begin
                    if (chr_low_q[0] == VRAM_ENABLE_CODE)
                        vram_off_q = 1'b0;
                    else if (chr_low_q[0] == VRAM_DISABLE_CODE)
                        vram_off_q = 1'b1;
                end
            end
        end

        if (irq_on_q)
        begin
            if (prescale_q < PRESCALE_WRAP)
                prescale_q += PRESCALE_STEP;
            else
            begin
                prescale_q -= PRESCALE_WRAP;
                if (irq_count_q != IRQ_CNT_TOP)
                    irq_count_q++;
                else
                begin
                    irq_count_q = irq_reload_q;
                    irq_pend_q  = 1'b1;
                end
            end
        end

        ps  = w.ppu_address[12:10];
        low = chr_low_q[ps];
        ram = (low == CHR_RAM_BANK_A || low == CHR_RAM_BANK_B) && !vram_off_q;
        r.prg_bank_low  = prg_bank_q[0];
        r.prg_bank_high = prg_bank_q[1];
        r.mirroring     = mirror_q;
        r.irq_line      = irq_pend_q;
        r.chr_from_ram  = ram;
        if (ram)
            r.chr_address = {11'h0, low[0], w.ppu_address[OFFSET_W-1:0]};
        else
        begin
            bank = clip_bank({chr_top_q[ps], low}, chr_limit_q);
            r.chr_address = {bank, w.ppu_address[OFFSET_W-1:0]};
        end
        r.chr_write_enable = ram && w.ppu_write;
        return r;
    endfunction

    function automatic in_word_t cyc(
        input bit wr, input logic [15:0] a, input logic [7:0] d,
        input logic [12:0] p, input bit pw
    );
        in_word_t w;
        w.cpu_write   = wr;
        w.cpu_address = a;
        w.cpu_data    = d;
        w.ppu_address = p;
        w.ppu_write   = pw;
        return w;
    endfunction

    function automatic out_word_t res(
        input logic [7:0] pl, input logic [7:0] ph, input logic [1:0] m, input bit irq,
        input bit ram, input logic [21:0] ca, input bit we
    );
        out_word_t r;
        r.prg_bank_low     = pl;
        r.prg_bank_high    = ph;
        r.mirroring        = m;
        r.irq_line         = irq;
        r.chr_from_ram     = ram;
        r.chr_address      = ca;
        r.chr_write_enable = we;
        return r;
    endfunction

    task automatic put(input in_word_t w, input bit typed, input out_word_t r);
        vector_t v;
        v.word   = w;
        v.typed  = typed;
        v.result = r;
        vectors.push_back(v);
    endtask

    function automatic in_word_t rand_word();
        in_word_t   w;
        int         pick;
        logic [3:0] nib;
        w.cpu_write   = ($urandom_range(99) < 35);
        w.cpu_data    = 8'($urandom_range(255));
        w.ppu_address = 13'($urandom_range(8191));
        w.ppu_write   = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 8)
            w.cpu_address = ADDR_PRG_LOW;
        else if (pick < 16)
            w.cpu_address = ADDR_PRG_HIGH;
        else if (pick < 22)
            w.cpu_address = ADDR_MIRROR;
        else if (pick < 34)
        begin
            w.cpu_address = (pick < 28) ? ADDR_RELOAD_LO : ADDR_RELOAD_HI;
            // reloads near the top make the irq fire often
            if ($urandom_range(9) < 7)
                w.cpu_data[3:0] = 4'hF;
        end
        else if (pick < 35)
        begin
            w.cpu_address = ADDR_IRQ_CTRL;
            w.cpu_data[1] = ($urandom_range(4) != 0);
        end
        else if (pick < 88)
        begin
            if (pick < 80)
                w.cpu_address = ADDR_CHR_FIRST + 16'(4096 * $urandom_range(3))
                                + 16'(4 * $urandom_range(3));
            else
                w.cpu_address = 16'($urandom_range(ADDR_CHR_LAST, ADDR_CHR_FIRST));
            // nibbles that build ram banks and the vram on/off codes
            if ($urandom_range(9) < 4)
            begin
                case ($urandom_range(4))
                    0: nib = CHR_RAM_BANK_A[3:0];
                    1: nib = CHR_RAM_BANK_B[3:0];
                    2: nib = VRAM_ENABLE_CODE[7:4];
                    3: nib = VRAM_DISABLE_CODE[7:4];
                    default: nib = 4'h0;
                endcase
                w.cpu_data = {($urandom_range(1) != 0) ? 4'($urandom) : 4'h0, nib};
            end
        end
        else
            w.cpu_address = 16'($urandom);
        return w;
    endfunction

    task automatic send_word(input in_word_t w, input bit typed, input out_word_t r);
        out_word_t e;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        e = step_mapper(w);
        mapped_due.push_back(typed ? r : e);
    endtask

    task automatic drain_pipeline();
        while (mapped_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_PRG_MAX)
            prg_limit_q = value[PRG_W-1:0];
        else if (idx == CFG_CHR_MAX)
            chr_limit_q = value;
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input longint unsigned e,
                               input longint unsigned a);
        if (e != a)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t %s mismatch: expected %0h actual %0h", $time, name, e, a);
        end
    endtask

    // output side: random stalls and the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (mapped_due.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t unexpected word: expected none actual %h", $time, out_word);
            end
            else
            begin
                due = mapped_due.pop_front();
                check_field("prg_bank_low", due.prg_bank_low, out_word.prg_bank_low);
                check_field("prg_bank_high", due.prg_bank_high, out_word.prg_bank_high);
                check_field("mirroring", due.mirroring, out_word.mirroring);
                check_field("irq_line", due.irq_line, out_word.irq_line);
                check_field("chr_from_ram", due.chr_from_ram, out_word.chr_from_ram);
                check_field("chr_address", due.chr_address, out_word.chr_address);
                check_field("chr_write_enable", due.chr_write_enable,
                            out_word.chr_write_enable);
                n_words++;
                n_irq_words  += due.irq_line;
                n_ram_words  += due.chr_from_ram;
                n_ram_writes += due.chr_write_enable;
            end
        end
        out_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        logic [PRG_W-1:0]      prg_lim;
        logic [CHR_BANK_W-1:0] chr_lim;

        errors       = 0;
        n_words      = 0;
        n_irq_words  = 0;
        n_ram_words  = 0;
        n_ram_writes = 0;
        n_settings   = 1;
        stall_cycles = 0;
        src_idle_pct = 16;
        snk_idle_pct = 46;
        reset_mapper();

        // after reset, extremes, then every register and the vram codes
        put(cyc(0, 16'h0000, 8'h00, 13'h0000, 0), 1, res(8'h00, 8'h00, 2'd0, 0, 0, 22'h0, 0));
        put(cyc(0, 16'hFFFF, 8'hFF, 13'h1FFF, 1), 1,
            res(8'h00, 8'h00, 2'd0, 0, 0, 22'h1FFF, 0));
        put(cyc(0, 16'h0000, 8'h00, 13'h1000, 1), 1, res(8'h00, 8'h00, 2'd0, 0, 1, 22'h0, 1));
        put(cyc(0, 16'h0000, 8'h00, 13'h17FF, 1), 1,
            res(8'h00, 8'h00, 2'd0, 0, 1, 22'h7FF, 1));
        put(cyc(1, ADDR_PRG_LOW, 8'hFF, 13'h0000, 0), 1,
            res(8'hFF, 8'h00, 2'd0, 0, 0, 22'h0, 0));
        put(cyc(1, ADDR_PRG_HIGH, 8'hFF, 13'h0000, 0), 1,
            res(8'hFF, 8'hFF, 2'd0, 0, 0, 22'h0, 0));
        put(cyc(1, ADDR_MIRROR, 8'hFF, 13'h0400, 0), 0, '0);
        put(cyc(1, ADDR_MIRROR, 8'h02, 13'h0800, 0), 0, '0);
        put(cyc(1, 16'h8011, 8'h55, 13'h0C00, 0), 0, '0);
        put(cyc(1, ADDR_CHR_FIRST - 16'd1, 8'hFF, 13'h1400, 1), 0, '0);
        put(cyc(1, ADDR_CHR_LAST + 16'd1, 8'hFF, 13'h1800, 1), 0, '0);
        put(cyc(1, 16'h0000, 8'h00, 13'h1C00, 0), 0, '0);
        put(cyc(1, 16'hFFFF, 8'hFF, 13'h03FF, 0), 0, '0);
        put(cyc(1, ADDR_RELOAD_LO, 8'hFF, 13'h0123, 0), 0, '0);
        put(cyc(1, ADDR_RELOAD_HI, 8'hFF, 13'h0456, 0), 0, '0);
        put(cyc(1, ADDR_IRQ_CTRL, 8'h02, 13'h0789, 0), 0, '0);
        put(cyc(1, ADDR_CHR_FIRST, 8'h08, 13'h0000, 1), 0, '0);
        put(cyc(1, ADDR_CHR_FIRST + 16'd4, 8'h58, 13'h1000, 1), 0, '0);
        put(cyc(1, ADDR_CHR_FIRST + 16'd4, 8'hFC, 13'h0000, 0), 0, '0);
        put(cyc(1, ADDR_CHR_LAST, 8'hFF, 13'h1C00, 1), 0, '0);
        put(cyc(1, 16'hD000, 8'h05, 13'h1000, 1), 0, '0);
        put(cyc(1, 16'hC008, 8'h00, 13'h0A00, 0), 0, '0);
        put(cyc(1, ADDR_IRQ_CTRL, 8'h00, 13'h1000, 1), 0, '0);
        put(cyc(1, ADDR_IRQ_CTRL, 8'hFD, 13'h1FFF, 1), 0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vectors[i])
            send_word(vectors[i].word, vectors[i].typed, vectors[i].result);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            in_valid <= 1'b0;
            drain_pipeline();
            case (seg)
                0: begin prg_lim = 8'h00; chr_lim = 12'h000; end
                1: begin prg_lim = 8'hFF; chr_lim = 12'hFFF; end
                3: begin prg_lim = 8'h3F; chr_lim = 12'h0FF; end
                default:
                begin
                    prg_lim = 8'($urandom);
                    chr_lim = 12'($urandom);
                end
            endcase
            write_limit(CFG_PRG_MAX, {4'($urandom), prg_lim});
            write_limit(CFG_CHR_MAX, chr_lim);
            write_limit((seg % 2 == 0) ? CFG_SPARE_A : CFG_SPARE_B, 12'($urandom));
            n_settings++;
            case (seg / 2)
                0: begin src_idle_pct = 16; snk_idle_pct = 46; end
                1: begin src_idle_pct = 46; snk_idle_pct = 16; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            repeat (SEGMENT_WORDS)
                send_word(rand_word(), 0, '0);
        end
        in_valid <= 1'b0;

        while (mapped_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("checked %0d words over %0d limit settings and three idle patterns",
                 n_words, n_settings);
        $display("irq high in %0d words, chr ram hit %0d times with %0d writes",
                 n_irq_words, n_ram_words, n_ram_writes);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
